FILE: hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define A_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define A_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/nkc_pkg.sv
// shared types and constants of the next k-combination stepper
package nkc_pkg;

    localparam int MAX_ELEMENTS_DEF  = 16;
    localparam int ELEMENT_WIDTH_DEF = 16;
    localparam int CFG_W   = 5;
    localparam int POS_W   = 5;
    localparam int INDEX_W = 4;
    localparam int VALUE_W = 16;

    localparam logic CFG_COUNT = 1'b0;
    localparam logic CFG_SPLIT = 1'b1;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_NEXT  = 2'd2;

    typedef enum logic [2:0] {
        RS_IDX  = 3'd0,
        RS_LAST = 3'd1,
        RS_P    = 3'd2,
        RS_J    = 3'd3,
        RS_A    = 3'd4,
        RS_B    = 3'd5
    } t_rsel;

    typedef enum logic [2:0] {
        WS_IDX = 3'd0,
        WS_P   = 3'd1,
        WS_J   = 3'd2,
        WS_A   = 3'd3,
        WS_B   = 3'd4
    } t_wsel;

    typedef enum logic [1:0] {
        ROT_A = 2'd0,
        ROT_B = 2'd1,
        ROT_W = 2'd2
    } t_rot;

    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    typedef struct packed {
        logic   re;
        t_rsel  rsel;
        logic   we;
        t_wsel  wsel;
        logic   init_p;
        logic   dec_p;
        logic   cap_last;
        logic   cap_pv;
        logic   init_j;
        logic   inc_j;
        logic   cap_ra;
        logic   rot_ld;
        t_rot   rot;
        logic   rev_ld;
        t_phase phase;
        logic   rev_step;
        logic   push;
        logic   push_rd;
        logic   push_adv;
    } t_cmd;

    typedef struct packed {
        logic invalid;
        logic idx_ok;
        logic lt_last;
        logic pv_lt;
        logic j_end;
        logic p_zero;
        logic rev_done;
        logic rot_skip;
        logic out_busy;
    } t_sts;

endpackage

FILE: hdl/nkc_ram.sv
// generic single-write, single-read ram with registered read
module nkc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/nkc_dpath.sv
// datapath: element store, scan pointers, rotation bounds, output register
module nkc_dpath import nkc_pkg::*; #(
    parameter int MAX_ELEMENTS  = MAX_ELEMENTS_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic [INDEX_W-1:0] i_index,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_out_stall,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic               o_out_valid,
    output logic [VALUE_W-1:0] o_read_value,
    output logic               o_advanced
);

    localparam int AW = $clog2(MAX_ELEMENTS);

    logic [CFG_W-1:0]         r_n, r_k;
    logic [POS_W-1:0]         r_p, r_j, r_lo, r_mid, r_hi, r_a, r_b;
    logic [ELEMENT_WIDTH-1:0] r_last, r_pv, r_ra;
    logic                     r_out_valid, r_out_adv;
    logic [VALUE_W-1:0]       r_out_rd;

    logic [AW-1:0]            raddr, waddr;
    logic [ELEMENT_WIDTH-1:0] wdata, rdata;
    logic [POS_W-1:0]         tail_mid;

    nkc_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(MAX_ELEMENTS)) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (i_cmd.re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        case (i_cmd.rsel)
            RS_IDX:  raddr = AW'(i_index);
            RS_LAST: raddr = AW'(r_n - CFG_W'(1));
            RS_P:    raddr = AW'(r_p);
            RS_J:    raddr = AW'(r_j);
            RS_A:    raddr = AW'(r_a);
            RS_B:    raddr = AW'(r_b);
            default: raddr = AW'(i_index);
        endcase
    end

    always_comb begin
        case (i_cmd.wsel)
            WS_IDX: begin
                waddr = AW'(i_index);
                wdata = ELEMENT_WIDTH'(i_value);
            end
            WS_P: begin
                waddr = AW'(r_p);
                wdata = rdata;
            end
            WS_J: begin
                waddr = AW'(r_j);
                wdata = r_pv;
            end
            WS_A: begin
                waddr = AW'(r_a);
                wdata = rdata;
            end
            WS_B: begin
                waddr = AW'(r_b);
                wdata = r_ra;
            end
            default: begin
                waddr = AW'(i_index);
                wdata = ELEMENT_WIDTH'(i_value);
            end
        endcase
    end

    // start of the shifted-down tail for the second rotation
    assign tail_mid = POS_W'(6'(r_k) + 6'(r_n) - 6'(r_j) - 6'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_COUNT) begin
                    r_n <= i_cfg_data;
                end else begin
                    r_k <= i_cfg_data;
                end
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_p) r_p <= r_k - CFG_W'(1);
        if (i_cmd.dec_p)  r_p <= r_p - POS_W'(1);
        if (i_cmd.init_j) r_j <= r_k;
        if (i_cmd.inc_j)  r_j <= r_j + POS_W'(1);
        if (i_cmd.cap_last) r_last <= rdata;
        if (i_cmd.cap_pv)   r_pv   <= rdata;
        if (i_cmd.cap_ra)   r_ra   <= rdata;
        if (i_cmd.rot_ld) begin
            r_hi <= r_n;
            case (i_cmd.rot)
                ROT_A: begin
                    r_lo  <= r_p + POS_W'(1);
                    r_mid <= r_j + POS_W'(1);
                end
                ROT_B: begin
                    r_lo  <= r_k;
                    r_mid <= tail_mid;
                end
                default: begin
                    r_lo  <= '0;
                    r_mid <= r_k;
                end
            endcase
        end
        if (i_cmd.rev_ld) begin
            case (i_cmd.phase)
                PH_0: begin
                    r_a <= r_lo;
                    r_b <= r_mid - POS_W'(1);
                end
                PH_1: begin
                    r_a <= r_mid;
                    r_b <= r_hi - POS_W'(1);
                end
                default: begin
                    r_a <= r_lo;
                    r_b <= r_hi - POS_W'(1);
                end
            endcase
        end
        if (i_cmd.rev_step) begin
            r_a <= r_a + POS_W'(1);
            r_b <= r_b - POS_W'(1);
        end
        if (i_cmd.push) begin
            r_out_rd  <= i_cmd.push_rd ? VALUE_W'(rdata) : '0;
            r_out_adv <= i_cmd.push_adv;
        end
    end

    always_comb begin
        o_sts.invalid  = (32'(r_n) > MAX_ELEMENTS) || (r_k > r_n) || (r_n < CFG_W'(2))
                         || (r_k == '0) || (r_k == r_n);
        o_sts.idx_ok   = 32'(i_index) < MAX_ELEMENTS;
        o_sts.lt_last  = rdata < r_last;
        o_sts.pv_lt    = r_pv < rdata;
        o_sts.j_end    = r_j == (r_n - CFG_W'(1));
        o_sts.p_zero   = r_p == '0;
        o_sts.rev_done = r_a >= r_b;
        o_sts.rot_skip = !((r_lo < r_mid) && (r_mid < r_hi));
        o_sts.out_busy = r_out_valid && i_out_stall;
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_rd;
    assign o_advanced   = r_out_adv;

endmodule

FILE: hdl/nkc_ctrl.sv
// controller: sequences writes, reads and the in-place combination step
module nkc_ctrl import nkc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_action,
    input  t_sts       i_sts,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_START = 16'h0002,
        S_LAST  = 16'h0004,
        S_PRD   = 16'h0008,
        S_PCHK  = 16'h0010,
        S_JRD   = 16'h0020,
        S_JCHK  = 16'h0040,
        S_SWP   = 16'h0080,
        S_SWJ   = 16'h0100,
        S_ROT   = 16'h0200,
        S_PH    = 16'h0400,
        S_RCHK  = 16'h0800,
        S_RRA   = 16'h1000,
        S_RRB   = 16'h2000,
        S_RWB   = 16'h4000,
        S_DONE  = 16'h8000
    } t_state;

    t_state r_state, n_state;
    t_rot   r_rot, n_rot;
    t_phase r_phase, n_phase;
    logic   r_rdok, n_rdok;
    logic   r_adv, n_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rot   <= ROT_A;
            r_phase <= PH_0;
            r_rdok  <= 1'b0;
            r_adv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rot   <= n_rot;
            r_phase <= n_phase;
            r_rdok  <= n_rdok;
            r_adv   <= n_adv;
        end
    end

    always_comb begin
        n_state = r_state;
        n_rot   = r_rot;
        n_phase = r_phase;
        n_rdok  = r_rdok;
        n_adv   = r_adv;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rdok  = 1'b0;
                    n_adv   = 1'b0;
                    n_state = S_DONE;
                    case (i_action)
                        ACT_WRITE: begin
                            o_cmd.we   = i_sts.idx_ok;
                            o_cmd.wsel = WS_IDX;
                        end
                        ACT_READ: begin
                            o_cmd.re   = 1'b1;
                            o_cmd.rsel = RS_IDX;
                            n_rdok     = i_sts.idx_ok;
                        end
                        ACT_NEXT: n_state = S_START;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_START: begin
                if (i_sts.invalid) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.re     = 1'b1;
                    o_cmd.rsel   = RS_LAST;
                    o_cmd.init_p = 1'b1;
                    n_state      = S_LAST;
                end
            end
            S_LAST: begin
                o_cmd.cap_last = 1'b1;
                n_state        = S_PRD;
            end
            S_PRD: begin
                o_cmd.re   = 1'b1;
                o_cmd.rsel = RS_P;
                n_state    = S_PCHK;
            end
            S_PCHK: begin
                if (i_sts.lt_last) begin
                    o_cmd.cap_pv = 1'b1;
                    o_cmd.init_j = 1'b1;
                    n_state      = S_JRD;
                end else if (i_sts.p_zero) begin
                    // no pivot: rotate back to the first combination
                    n_rot   = ROT_W;
                    n_state = S_ROT;
                end else begin
                    o_cmd.dec_p = 1'b1;
                    n_state     = S_PRD;
                end
            end
            S_JRD: begin
                o_cmd.re   = 1'b1;
                o_cmd.rsel = RS_J;
                n_state    = S_JCHK;
            end
            S_JCHK: begin
                if (i_sts.pv_lt || i_sts.j_end) begin
                    n_state = S_SWP;
                end else begin
                    o_cmd.inc_j = 1'b1;
                    n_state     = S_JRD;
                end
            end
            S_SWP: begin
                // read data still holds the successor
                o_cmd.we   = 1'b1;
                o_cmd.wsel = WS_P;
                n_state    = S_SWJ;
            end
            S_SWJ: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsel = WS_J;
                n_rot      = ROT_A;
                n_state    = S_ROT;
            end
            S_ROT: begin
                o_cmd.rot_ld = 1'b1;
                o_cmd.rot    = r_rot;
                n_phase      = PH_0;
                n_state      = S_PH;
            end
            S_PH: begin
                if (i_sts.rot_skip) begin
                    n_phase = PH_2;
                    n_state = S_RCHK;
                end else begin
                    o_cmd.rev_ld = 1'b1;
                    o_cmd.phase  = r_phase;
                    n_state      = S_RCHK;
                end
            end
            S_RCHK: begin
                if (i_sts.rev_done || i_sts.rot_skip) begin
                    case (r_phase)
                        PH_0: begin
                            n_phase = PH_1;
                            n_state = S_PH;
                        end
                        PH_1: begin
                            n_phase = PH_2;
                            n_state = S_PH;
                        end
                        default: begin
                            // rotation finished
                            case (r_rot)
                                ROT_A: begin
                                    n_rot   = ROT_B;
                                    n_state = S_ROT;
                                end
                                ROT_B: begin
                                    n_adv   = 1'b1;
                                    n_state = S_DONE;
                                end
                                default: begin
                                    n_adv   = 1'b0;
                                    n_state = S_DONE;
                                end
                            endcase
                        end
                    endcase
                end else begin
                    o_cmd.re   = 1'b1;
                    o_cmd.rsel = RS_A;
                    n_state    = S_RRA;
                end
            end
            S_RRA: begin
                o_cmd.cap_ra = 1'b1;
                o_cmd.re     = 1'b1;
                o_cmd.rsel   = RS_B;
                n_state      = S_RRB;
            end
            S_RRB: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsel = WS_A;
                n_state    = S_RWB;
            end
            S_RWB: begin
                o_cmd.we       = 1'b1;
                o_cmd.wsel     = WS_B;
                o_cmd.rev_step = 1'b1;
                n_state        = S_RCHK;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_rd  = r_rdok;
                    o_cmd.push_adv = r_adv;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

FILE: hdl/next_k_combination_step_top.sv
// a write, read or unused transaction goes from idle to the done state, which loads the output
// register once no stalled result waits; a next step reads the last entry, probes from k-1
// down for the pivot and from k up for its successor, swaps them and rotates by reversal swaps
// (a skipped rotation swaps nothing; without a pivot one rotation wraps to the start)
// one read and one write port on the store; one transaction at a time; a new one is taken
// while a result waits; sync active-low reset clears n, k, out valid, control; store is kept
`include "assert_macros.svh"
module next_k_combination_step_top import nkc_pkg::*; #(
    parameter int MAX_ELEMENTS  = MAX_ELEMENTS_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [INDEX_W-1:0] i_index,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [VALUE_W-1:0] o_read_value,
    output logic               o_advanced
);

    t_cmd cmd;
    t_sts sts;

    nkc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_action  (i_action),
        .i_sts     (sts),
        .o_in_stall(o_in_stall),
        .o_cmd     (cmd)
    );

    nkc_dpath #(.MAX_ELEMENTS(MAX_ELEMENTS), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_read_value(o_read_value),
        .o_advanced  (o_advanced)
    );

    // an accepted transaction makes the block busy
    `A_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // a step result never carries a read value
    `A_IMPL(a_adv_no_read, i_clk, i_rst_n, o_out_valid && o_advanced, o_read_value == '0)

endmodule
